// ----- sv/pcpa_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpa_pkg
// types and constants shared by the per-cpu page frame allocator modules
// ----------------------------------------------------------------------------
package pcpa_pkg;

   localparam int PAGE_W  = 10;
   localparam int CPU_W   = 3;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'd2047;
   localparam logic [COUNT_W-1:0] BATCH_RESET = 11'd1000;
   localparam logic [6:0]         WITHDRAW_FACTOR = 7'd100;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_SEED  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOMEM = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      CSR_REFILL_BATCH = 1'b0,
      CSR_FIRST_PAGE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type             operation;
      logic [CPU_W-1:0]   cpu;
      logic [PAGE_W-1:0]  page;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [PAGE_W-1:0]  page_out;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WD_CHECK,
      S_WD_SPLICE,
      S_WD_END,
      S_RF_START,
      S_RF_SPLICE,
      S_POP_START,
      S_POP_FINISH,
      S_WK_REQ,
      S_WK_RSP,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      CTX_WD,
      CTX_RF,
      CTX_POP
   } ctx_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       push_cpu;
      logic       push_pool;
      logic       wd_init;
      logic       wd_start;
      logic       wd_splice;
      logic       sel_next;
      logic       sel_req;
      logic       rf_start;
      logic       rf_splice;
      logic       pop_start;
      logic       pop_finish;
      logic       walk_step;
      logic       set_res;
      status_type res_status;
      logic       load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   range_ok;
      logic   count_zero;
      logic   pool_zero;
      logic   walk_last;
      logic   gain_reached;
      logic   gain_zero;
      logic   sel_last;
      logic   rsp_free;
   } stat_type;

endpackage

// ----- sv/per_cpu_page_frame_allocator.sv -----
// free and seed: decode sets the result, done loads it once the output register is free
// allocate from a non-empty cpu list: pop_start, a walk step, pop_finish, then done
// a refill adds rf_start, a walk step per frame and rf_splice; a withdraw adds wd_check
// per list, walk steps and wd_splice per non-empty list, then wd_end
// synchronous reset clears the list counts and gain, restores refill_batch to 1000, first_page to 0
// ----------------------------------------------------------------------------
// per_cpu_page_frame_allocator
// page frame allocator with a central pool and per-cpu lifo free lists
// ----------------------------------------------------------------------------
module per_cpu_page_frame_allocator
   import pcpa_pkg::*;
#(
   parameter int NUM_PAGES = 1024,
   parameter int NUM_CPUS  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   pcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // lists, link memory and result registers
   pcpa_datapath #(
      .NUM_PAGES (NUM_PAGES),
      .NUM_CPUS  (NUM_CPUS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- sv/pcpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcpa_ctrl
// sequencer for free, seed, pop, refill and withdraw walks
// ----------------------------------------------------------------------------
module pcpa_ctrl
   import pcpa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   ctx_type   ctx_ff, ctx_in;

   // state and walk context registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctx_ff   <= CTX_POP;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ctx_in   = ctx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_ALLOC: begin
                  if (!stat.count_zero)     state_in = S_POP_START;
                  else if (!stat.pool_zero) state_in = S_RF_START;
                  else                      state_in = S_WD_CHECK;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WD_CHECK: begin
            if (stat.gain_reached) begin
               state_in = S_WD_END;
            end else if (!stat.count_zero) begin
               state_in = S_WK_REQ;
               ctx_in   = CTX_WD;
            end else if (stat.sel_last) begin
               state_in = S_WD_END;
            end
         end
         S_WD_SPLICE: begin
            state_in = stat.sel_last ? S_WD_END : S_WD_CHECK;
         end
         S_WD_END: begin
            state_in = stat.gain_zero ? S_DONE : S_RF_START;
         end
         S_RF_START: begin
            state_in = S_WK_REQ;
            ctx_in   = CTX_RF;
         end
         S_RF_SPLICE: state_in = S_POP_START;
         S_POP_START: begin
            state_in = S_WK_REQ;
            ctx_in   = CTX_POP;
         end
         S_POP_FINISH: state_in = S_DONE;
         S_WK_REQ:     state_in = S_WK_RSP;
         S_WK_RSP: begin
            if (!stat.walk_last) begin
               state_in = S_WK_REQ;
            end else begin
               unique case (ctx_ff)
                  CTX_WD:  state_in = S_WD_SPLICE;
                  CTX_RF:  state_in = S_RF_SPLICE;
                  default: state_in = S_POP_FINISH;
               endcase
            end
         end
         S_DONE: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.res_status = ST_OK;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            unique case (stat.op) inside
               OP_ALLOC: begin
                  cmd.wd_init = stat.count_zero && stat.pool_zero;
               end
               OP_FREE, OP_SEED: begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = stat.range_ok ? ST_OK : ST_RANGE;
                  cmd.push_cpu   = stat.range_ok && (stat.op == OP_FREE);
                  cmd.push_pool  = stat.range_ok && (stat.op == OP_SEED);
               end
               default: begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_OK;
               end
            endcase
         end
         S_WD_CHECK: begin
            if (!stat.gain_reached) begin
               cmd.wd_start = !stat.count_zero;
               cmd.sel_next = stat.count_zero && !stat.sel_last;
            end
         end
         S_WD_SPLICE: begin
            cmd.wd_splice = 1'b1;
            cmd.sel_next  = !stat.sel_last;
         end
         S_WD_END: begin
            cmd.sel_req    = 1'b1;
            cmd.set_res    = stat.gain_zero;
            cmd.res_status = ST_NOMEM;
         end
         S_RF_START:   cmd.rf_start = 1'b1;
         S_RF_SPLICE:  cmd.rf_splice = 1'b1;
         S_POP_START:  cmd.pop_start = 1'b1;
         S_POP_FINISH: begin
            cmd.pop_finish = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
         end
         S_WK_RSP:     cmd.walk_step = 1'b1;
         S_DONE:       cmd.load_rsp = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

// ----- sv/pcpa_datapath.sv -----
// ----------------------------------------------------------------------------
// pcpa_datapath
// list heads and counts, link memory, walk pointer, config and result registers
// ----------------------------------------------------------------------------
module pcpa_datapath
   import pcpa_pkg::*;
#(
   parameter int NUM_PAGES = 1024,
   parameter int NUM_CPUS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  cmd_type            cmd,
   output stat_type           stat
);

   localparam int MEM_DEPTH = (NUM_PAGES < 1024) ? NUM_PAGES : 1024;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int CW        = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

   // cpu index wraps into range by repeated subtraction
   function automatic logic [CW-1:0] cpu_wrap(input logic [CPU_W-1:0] c);
      logic [CPU_W-1:0] v;
      v = c;
      for (int k = 0; k < 8; k++) begin
         if (32'(v) >= NUM_CPUS) v = CPU_W'(32'(v) - NUM_CPUS);
      end
      return CW'(v);
   endfunction

   logic [PAGE_W-1:0]  cpu_head_ff  [NUM_CPUS];
   logic [COUNT_W-1:0] cpu_count_ff [NUM_CPUS];
   logic [PAGE_W-1:0]  pool_head_ff;
   logic [COUNT_W-1:0] pool_count_ff;
   logic [PAGE_W-1:0]  link_mem [MEM_DEPTH];
   logic [PAGE_W-1:0]  rdata_ff;

   logic [COUNT_W-1:0] batch_ff;
   logic [PAGE_W-1:0]  first_ff;
   op_type             op_ff;
   logic [CW-1:0]      cpu_ff, sel_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [COUNT_W-1:0] gain_ff, take_ff, steps_ff;
   logic [PAGE_W-1:0]  cur_ff, last_ff;
   status_type         res_status_ff;
   logic [PAGE_W-1:0]  res_page_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [COUNT_W-1:0] batch_eff, limit, sel_count, remain, take_wd, move;
   logic [PAGE_W-1:0]  sel_head;
   logic [17:0]        limit_full;
   logic               range_ok;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [PAGE_W-1:0]  mem_wdata;

   // derived batch and withdraw limit
   always_comb begin
      batch_eff  = (batch_ff == '0) ? COUNT_W'(1) : batch_ff;
      limit_full = 18'(batch_eff) * 18'(WITHDRAW_FACTOR);
      limit      = (limit_full > 18'(COUNT_MAX)) ? COUNT_MAX : limit_full[COUNT_W-1:0];
      sel_count  = cpu_count_ff[sel_ff];
      sel_head   = cpu_head_ff[sel_ff];
      remain     = limit - gain_ff;
      take_wd    = (sel_count > remain) ? remain : sel_count;
      move       = (pool_count_ff < batch_eff) ? pool_count_ff : batch_eff;
      range_ok   = (page_ff >= first_ff) && (32'(page_ff) < NUM_PAGES);
   end

   // status to controller
   always_comb begin
      stat.op           = op_ff;
      stat.range_ok     = range_ok;
      stat.count_zero   = (sel_count == '0);
      stat.pool_zero    = (pool_count_ff == '0);
      stat.walk_last    = (steps_ff == COUNT_W'(1));
      stat.gain_reached = (gain_ff >= limit);
      stat.gain_zero    = (gain_ff == '0);
      stat.sel_last     = (sel_ff == CW'(NUM_CPUS - 1));
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= BATCH_RESET;
         first_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_REFILL_BATCH: batch_ff <= csr_wdata;
            CSR_FIRST_PAGE:   first_ff <= csr_wdata[PAGE_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture and cpu select
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_data.operation;
         page_ff <= req_data.page;
         cpu_ff  <= cpu_wrap(req_data.cpu);
         sel_ff  <= cpu_wrap(req_data.cpu);
      end else if (cmd.wd_init) begin
         sel_ff <= '0;
      end else if (cmd.sel_next) begin
         sel_ff <= sel_ff + CW'(1);
      end else if (cmd.sel_req) begin
         sel_ff <= cpu_ff;
      end
   end

   // walk pointer: cur steps along links, last trails by one
   always_ff @(posedge clock) begin
      if (cmd.wd_start) begin
         cur_ff   <= sel_head;
         steps_ff <= take_wd;
         take_ff  <= take_wd;
      end else if (cmd.rf_start) begin
         cur_ff   <= pool_head_ff;
         steps_ff <= move;
         take_ff  <= move;
      end else if (cmd.pop_start) begin
         cur_ff   <= sel_head;
         steps_ff <= COUNT_W'(1);
      end else if (cmd.walk_step) begin
         last_ff  <= cur_ff;
         cur_ff   <= rdata_ff;
         steps_ff <= steps_ff - COUNT_W'(1);
      end
   end

   // withdraw gain
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else if (cmd.wd_init) begin
         gain_ff <= '0;
      end else if (cmd.wd_splice) begin
         gain_ff <= gain_ff + take_ff;
      end
   end

   // cpu list heads
   always_ff @(posedge clock) begin
      if (cmd.push_cpu && (sel_count != COUNT_MAX)) begin
         cpu_head_ff[sel_ff] <= page_ff;
      end else if (cmd.wd_splice || cmd.pop_finish) begin
         cpu_head_ff[sel_ff] <= cur_ff;
      end else if (cmd.rf_splice) begin
         cpu_head_ff[sel_ff] <= pool_head_ff;
      end
   end

   // cpu list counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) cpu_count_ff[i] <= '0;
      end else if (cmd.push_cpu && (sel_count != COUNT_MAX)) begin
         cpu_count_ff[sel_ff] <= sel_count + COUNT_W'(1);
      end else if (cmd.wd_splice) begin
         cpu_count_ff[sel_ff] <= sel_count - take_ff;
      end else if (cmd.rf_splice) begin
         cpu_count_ff[sel_ff] <= take_ff;
      end else if (cmd.pop_finish) begin
         cpu_count_ff[sel_ff] <= sel_count - COUNT_W'(1);
      end
   end

   // pool head and count
   always_ff @(posedge clock) begin
      if (cmd.push_pool && (pool_count_ff != COUNT_MAX)) begin
         pool_head_ff <= page_ff;
      end else if (cmd.wd_splice) begin
         pool_head_ff <= sel_head;
      end else if (cmd.rf_splice) begin
         pool_head_ff <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_count_ff <= '0;
      end else if (cmd.push_pool && (pool_count_ff != COUNT_MAX)) begin
         pool_count_ff <= pool_count_ff + COUNT_W'(1);
      end else if (cmd.wd_splice) begin
         pool_count_ff <= pool_count_ff + take_ff;
      end else if (cmd.rf_splice) begin
         pool_count_ff <= pool_count_ff - take_ff;
      end
   end

   // link memory write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = page_ff[AW-1:0];
      mem_wdata = sel_head;
      if (cmd.push_cpu && (sel_count != COUNT_MAX)) begin
         mem_we = 1'b1;
      end else if (cmd.push_pool && (pool_count_ff != COUNT_MAX)) begin
         mem_we    = 1'b1;
         mem_wdata = pool_head_ff;
      end else if (cmd.wd_splice) begin
         mem_we    = 1'b1;
         mem_waddr = last_ff[AW-1:0];
         mem_wdata = pool_head_ff;
      end
   end

   // link memory, registered read at the walk pointer
   always_ff @(posedge clock) begin
      if (mem_we) link_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= link_mem[cur_ff[AW-1:0]];
   end

   // result held until the output register is free
   always_ff @(posedge clock) begin
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_page_ff   <= cmd.pop_finish ? last_ff : '0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status   <= res_status_ff;
         rsp_ff.page_out <= res_page_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
